@@ design/dasrp_pkg.sv @@
// Package for the deduplicating address set with random pop.
// Holds the sequencer state type, command and status codes and the LFSR step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dasrp_pkg;

    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 48;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 7;
    localparam int CFG_DATA_W = 32;
    localparam int LFSR_W     = 32;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_ERASE = 2'd1,
        CMD_POP   = 2'd2,
        CMD_LIST  = 2'd3
    } cmd_t;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_PRESENT   = 3'd1;
    localparam status_t ST_NOT_FOUND = 3'd2;
    localparam status_t ST_EMPTY     = 3'd3;
    localparam status_t ST_FULL      = 3'd4;
    localparam status_t ST_REJECTED  = 3'd5;

    localparam logic REG_MAX_ENTRIES = 1'b0;
    localparam logic REG_RNG_SEED    = 1'b1;

    localparam logic [COUNT_W-1:0]    MAX_ENTRIES_RESET = 7'd64;
    localparam logic [CFG_DATA_W-1:0] RNG_SEED_RESET    = 32'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_SHIFT,
        S_MOD,
        S_POP_RD1,
        S_POP_RD2,
        S_POP_WR
    } state_t;

    // One step of the Galois LFSR: shift right, fold the taps in on a one.
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        begin
            s = v >> 1;
            if (v[0])
            begin
                s = s ^ LFSR_TAPS;
            end
            return s;
        end
    endfunction

endpackage

`default_nettype wire

@@ design/dedup_address_set_random_pop.sv @@
// Top level of the deduplicating address set with random pop.
// Holds the entry memory and the command sequencer. Uses dasrp_pkg and dasrp_mod.
//
//  channel   signals                                  handshake
//  -------   ---------------------------------------  --------------------------
//  command   start, cmd, addr, list_last              taken when start & !busy
//  result    done, status, addr_out, count_out        valid for the done cycle
//  config    cfg_valid, cfg_index, cfg_data           taken when valid & ready
//
// A push, erase or list element scans the stored entries one per cycle through
// the single memory read port. An erase that finds its key then moves the later
// entries down one place a cycle. A non-empty pop returns the entry at the LFSR
// value modulo the count (bit-serial remainder unit), moving the last entry there.
// After reset the set is empty and max_entries = 64, LFSR = 1; no clearing pass.
// The receiver cannot stall: each result shows for one cycle with done high.
`timescale 1ns / 1ps
`default_nettype none

module dedup_address_set_random_pop #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 48
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [dasrp_pkg::CMD_W-1:0]      cmd,
    input  wire logic [dasrp_pkg::ADDR_W-1:0]     addr,
    input  wire logic                             list_last,
    output logic                                  done,
    output logic [dasrp_pkg::STATUS_W-1:0]        status,
    output logic [dasrp_pkg::ADDR_W-1:0]          addr_out,
    output logic [dasrp_pkg::COUNT_W-1:0]         count_out,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic                             cfg_index,
    input  wire logic [dasrp_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int KW   = (KEY_BITS < dasrp_pkg::ADDR_W) ? KEY_BITS : dasrp_pkg::ADDR_W;
    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > dasrp_pkg::COUNT_W) ? CW : dasrp_pkg::COUNT_W;

    logic [KW-1:0] mem [DEPTH];

    dasrp_pkg::state_t state_reg, state_next;
    dasrp_pkg::cmd_t   cmd_reg;
    logic [KW-1:0]     key_reg;
    logic              last_reg;

    logic [CW-1:0]                       count_reg, count_next;
    logic [dasrp_pkg::LFSR_W-1:0]        lfsr_reg, lfsr_next;
    logic [dasrp_pkg::COUNT_W-1:0]       max_reg;
    logic                                list_active_reg, list_active_next;
    logic                                list_skip_reg, list_skip_next;
    logic [CW-1:0]                       list_base_reg, list_base_next;
    logic [CW-1:0]                       issue_reg, issue_next;
    logic [CW-1:0]                       limit_reg, limit_next;
    logic [AW-1:0]                       pos_reg, pos_next;
    logic [KW-1:0]                       got_reg, got_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [KW-1:0] rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [KW-1:0] wr_data;

    logic                          fin;
    dasrp_pkg::status_t            fin_status;
    logic [KW-1:0]                 fin_addr;
    logic                          done_reg;
    dasrp_pkg::status_t            status_reg;
    logic [dasrp_pkg::ADDR_W-1:0]  addr_out_reg;
    logic [dasrp_pkg::COUNT_W-1:0] count_out_reg;

    logic                          accept;
    logic                          match;
    logic [CW-1:0]                 last_idx;
    logic                          mod_start;
    logic                          mod_done;
    logic [CW-1:0]                 mod_rem;

    assign busy      = (state_reg != dasrp_pkg::S_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign match     = rd_vld_reg && (rd_data_reg == key_reg);
    assign last_idx  = count_reg - CW'(1);

    dasrp_mod #(
        .DIV_W (CW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (lfsr_next),
        .divisor  (count_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        lfsr_next        = lfsr_reg;
        list_active_next = list_active_reg;
        list_skip_next   = list_skip_reg;
        list_base_next   = list_base_reg;
        issue_next       = issue_reg;
        limit_next       = limit_reg;
        pos_next         = pos_reg;
        got_next         = got_reg;
        rd_en            = 1'b0;
        rd_addr          = issue_reg[AW-1:0];
        wr_en            = 1'b0;
        wr_addr          = count_reg[AW-1:0];
        wr_data          = key_reg;
        fin              = 1'b0;
        fin_status       = dasrp_pkg::ST_OK;
        fin_addr         = '0;
        mod_start        = 1'b0;

        unique case (state_reg)
            dasrp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = dasrp_pkg::S_DISPATCH;
                    if (dasrp_pkg::cmd_t'(cmd) != dasrp_pkg::CMD_LIST)
                    begin
                        list_active_next = 1'b0;
                        list_skip_next   = 1'b0;
                    end
                    else if (!list_active_reg)
                    begin
                        list_active_next = 1'b1;
                        list_base_next   = count_reg;
                        list_skip_next   = CMPW'(count_reg) > CMPW'(max_reg);
                    end
                end
            end

            dasrp_pkg::S_DISPATCH:
            begin
                issue_next = '0;
                case (cmd_reg) inside
                    dasrp_pkg::CMD_PUSH, dasrp_pkg::CMD_ERASE:
                    begin
                        limit_next = count_reg;
                        state_next = dasrp_pkg::S_SEARCH;
                    end
                    dasrp_pkg::CMD_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            fin        = 1'b1;
                            fin_status = dasrp_pkg::ST_EMPTY;
                            state_next = dasrp_pkg::S_IDLE;
                        end
                        else
                        begin
                            lfsr_next  = dasrp_pkg::lfsr_step(lfsr_reg);
                            mod_start  = 1'b1;
                            state_next = dasrp_pkg::S_MOD;
                        end
                    end
                    default:
                    begin
                        if (list_skip_reg)
                        begin
                            fin        = 1'b1;
                            fin_status = dasrp_pkg::ST_REJECTED;
                            state_next = dasrp_pkg::S_IDLE;
                        end
                        else
                        begin
                            limit_next = list_base_reg;
                            state_next = dasrp_pkg::S_SEARCH;
                        end
                    end
                endcase
            end

            dasrp_pkg::S_SEARCH:
            begin
                // Reads are pipelined: the entry read last cycle is compared now.
                if (match)
                begin
                    if (cmd_reg == dasrp_pkg::CMD_ERASE)
                    begin
                        issue_next = CW'(rd_idx_reg) + CW'(1);
                        state_next = dasrp_pkg::S_SHIFT;
                    end
                    else
                    begin
                        fin        = 1'b1;
                        fin_status = dasrp_pkg::ST_PRESENT;
                        state_next = dasrp_pkg::S_IDLE;
                    end
                end
                else if (issue_reg < limit_reg)
                begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + CW'(1);
                end
                else if (!rd_vld_reg)
                begin
                    fin        = 1'b1;
                    state_next = dasrp_pkg::S_IDLE;
                    if (cmd_reg == dasrp_pkg::CMD_ERASE)
                    begin
                        fin_status = dasrp_pkg::ST_NOT_FOUND;
                    end
                    else if (count_reg == CW'(DEPTH))
                    begin
                        fin_status = dasrp_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
            end

            dasrp_pkg::S_SHIFT:
            begin
                if (issue_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + CW'(1);
                end
                if (rd_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg - AW'(1);
                    wr_data = rd_data_reg;
                end
                else if (issue_reg >= count_reg)
                begin
                    count_next = last_idx;
                    fin        = 1'b1;
                    state_next = dasrp_pkg::S_IDLE;
                end
            end

            dasrp_pkg::S_MOD:
            begin
                if (mod_done)
                begin
                    pos_next   = mod_rem[AW-1:0];
                    state_next = dasrp_pkg::S_POP_RD1;
                end
            end

            dasrp_pkg::S_POP_RD1:
            begin
                rd_en      = 1'b1;
                rd_addr    = pos_reg;
                state_next = dasrp_pkg::S_POP_RD2;
            end

            dasrp_pkg::S_POP_RD2:
            begin
                got_next   = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = last_idx[AW-1:0];
                state_next = dasrp_pkg::S_POP_WR;
            end

            dasrp_pkg::S_POP_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = rd_data_reg;
                count_next = last_idx;
                fin        = 1'b1;
                fin_addr   = got_reg;
                state_next = dasrp_pkg::S_IDLE;
            end

            default:
            begin
                state_next = dasrp_pkg::S_IDLE;
            end
        endcase

        // The final element of a list closes it once its result is out.
        if (fin && (cmd_reg == dasrp_pkg::CMD_LIST) && last_reg)
        begin
            list_active_next = 1'b0;
            list_skip_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dasrp_pkg::S_IDLE;
            count_reg       <= '0;
            lfsr_reg        <= dasrp_pkg::RNG_SEED_RESET;
            max_reg         <= dasrp_pkg::MAX_ENTRIES_RESET;
            list_active_reg <= 1'b0;
            list_skip_reg   <= 1'b0;
            list_base_reg   <= '0;
            rd_vld_reg      <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            list_active_reg <= list_active_next;
            list_skip_reg   <= list_skip_next;
            list_base_reg   <= list_base_next;
            rd_vld_reg      <= rd_en;
            done_reg        <= fin;
            // A seed write reloads the LFSR; writes only land while idle.
            if (cfg_valid && cfg_ready && (cfg_index == dasrp_pkg::REG_RNG_SEED))
            begin
                lfsr_reg <= cfg_data;
            end
            else
            begin
                lfsr_reg <= lfsr_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    dasrp_pkg::REG_MAX_ENTRIES:
                    begin
                        max_reg <= cfg_data[dasrp_pkg::COUNT_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg  <= issue_next;
        limit_reg  <= limit_next;
        pos_reg    <= pos_next;
        got_reg    <= got_next;
        rd_idx_reg <= rd_addr;
        if (accept)
        begin
            cmd_reg  <= dasrp_pkg::cmd_t'(cmd);
            key_reg  <= addr[KW-1:0];
            last_reg <= list_last;
        end
        if (fin)
        begin
            status_reg    <= fin_status;
            addr_out_reg  <= dasrp_pkg::ADDR_W'(fin_addr);
            count_out_reg <= dasrp_pkg::COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign addr_out  = addr_out_reg;
    assign count_out = count_out_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while the sequencer is still working");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond the store depth");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted transaction did not start the sequencer");

    a_mod_state: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == dasrp_pkg::S_MOD))
        else $error("remainder finished outside the pop sequence");

endmodule

`default_nettype wire

@@ design/dasrp_mod.sv @@
// Iterative remainder unit: one restoring subtract step per cycle.
// Reduces the 32-bit LFSR value modulo the live entry count. Uses dasrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dasrp_mod #(
    parameter int DIV_W = 7
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [dasrp_pkg::LFSR_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]             divisor,
    output logic                              done,
    output logic [DIV_W-1:0]                  rem
);

    localparam int STEP_W = $clog2(dasrp_pkg::LFSR_W);

    logic                         active_reg;
    logic                         done_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [dasrp_pkg::LFSR_W-1:0] dvd_reg;
    logic [DIV_W-1:0]             dvs_reg;
    logic [DIV_W-1:0]             rem_reg;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic [DIV_W-1:0] rem_next;

    // The partial remainder stays below the divisor, so the trial value stays
    // below twice the divisor and one subtract brings it back into range.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[dasrp_pkg::LFSR_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = (trial >= {1'b0, dvs_reg}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                step_reg   <= STEP_W'(dasrp_pkg::LFSR_W - 1);
            end
            else if (active_reg)
            begin
                if (step_reg == '0)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (active_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire
